@@ src/dctrtc_pkg.sv @@
// Shared types, constants and calendar helpers for the day count to clock image unit.
package dctrtc_pkg;

  localparam logic [15:0] DAY_LAST     = 16'd36525;
  localparam logic [3:0]  YY_UNITS_0   = 4'd8;
  localparam logic [3:0]  YY_TENS_0    = 4'd7;
  localparam logic [1:0]  YMOD4_0      = 2'd2;
  localparam logic [3:0]  MODE_24H     = 4'h8;
  localparam logic [3:0]  MONTH_LAST   = 4'd12;
  localparam logic [8:0]  YEAR_LEN     = 9'd365;
  localparam logic [8:0]  LEAP_LEN     = 9'd366;
  localparam int          IMG_W        = 52;

  typedef struct packed {
    logic load;
    logic year_step;
    logic month_step;
    logic add_day;
    logic fix_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic year_fits;
    logic month_fits;
    logic fix_done;
  } stat_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    begin
      case (m)
        4'd2:    len = leap ? 5'd29 : 5'd28;
        4'd4:    len = 5'd30;
        4'd6:    len = 5'd30;
        4'd9:    len = 5'd30;
        4'd11:   len = 5'd30;
        default: len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

@@ src/dctrtc_in_if.sv @@
// Request channel carrying the day count and BCD time.
interface dctrtc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] date_word;
  logic [7:0]  hour_bcd;
  logic [7:0]  minute_bcd;
  logic [7:0]  second_bcd;

  modport source (output valid, output date_word, output hour_bcd, output minute_bcd,
                  output second_bcd, input ready);
  modport sink (input valid, input date_word, input hour_bcd, input minute_bcd,
                input second_bcd, output ready);
endinterface

@@ src/dctrtc_out_if.sv @@
// Result channel carrying the status and the clock register image.
interface dctrtc_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [51:0] register_image;

  modport source (output valid, output status, output register_image, input ready);
  modport sink (input valid, input status, input register_image, output ready);
endinterface

@@ src/day_count_time_to_rtc_image_unit.sv @@
// Top level: day count and BCD time to a 13-nibble clock register image.
// Sequence: a rejected request goes from the year state straight to the finish state;
//   otherwise the unit walks years, then months, adds the day and runs the fix-up steps.
// Throughput: one request at a time; the next is taken once the previous one
//   reaches the output register. The year walk handles one year per cycle.
// Reset: synchronous active-high rst idles the sequencer and clears the output valid.
module day_count_time_to_rtc_image_unit (
  input  logic                clk,
  input  logic                rst,
  dctrtc_in_if.sink           in_ch,
  dctrtc_out_if.source        out_ch
);
  import dctrtc_pkg::*;

  cmd_t  cmd;
  stat_t st;

  dctrtc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  dctrtc_dp u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .st             (st),
    .date_word      (in_ch.date_word),
    .hour_bcd       (in_ch.hour_bcd),
    .minute_bcd     (in_ch.minute_bcd),
    .second_bcd     (in_ch.second_bcd),
    .status         (out_ch.status),
    .register_image (out_ch.register_image)
  );

endmodule

@@ src/dctrtc_ctrl.sv @@
// Sequencer for the year walk, month walk, weekday fix-up and result handoff.
module dctrtc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  dctrtc_pkg::stat_t   st,
  output dctrtc_pkg::cmd_t    cmd
);
  import dctrtc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_YEAR   = 3'd1;
  localparam logic [2:0] S_MONTH  = 3'd2;
  localparam logic [2:0] S_ADDDAY = 3'd3;
  localparam logic [2:0] S_FIX    = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_YEAR;
        end
      end
      S_YEAR: begin
        if (st.bad) begin
          state_next = S_FINISH;
        end else if (st.year_fits) begin
          state_next = S_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      S_MONTH: begin
        if (st.month_fits) begin
          state_next = S_ADDDAY;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      S_ADDDAY: begin
        cmd.add_day = 1'b1;
        state_next  = S_FIX;
      end
      S_FIX: begin
        if (st.fix_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.fix_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/dctrtc_dp.sv @@
// Datapath: input checks, year and month walk registers, weekday and image assembly.
module dctrtc_dp (
  input  logic                clk,
  input  dctrtc_pkg::cmd_t    cmd,
  output dctrtc_pkg::stat_t   st,
  input  logic [15:0]         date_word,
  input  logic [7:0]          hour_bcd,
  input  logic [7:0]          minute_bcd,
  input  logic [7:0]          second_bcd,
  output logic                status,
  output logic [51:0]         register_image
);
  import dctrtc_pkg::*;

  logic [15:0] n;
  logic [7:0]  hr;
  logic [7:0]  mi;
  logic [7:0]  se;
  logic        bad;
  logic [1:0]  ymod4;
  logic [3:0]  yy_units;
  logic [3:0]  yy_tens;
  logic [3:0]  month;
  logic [5:0]  wacc;
  logic [1:0]  dtens;

  logic        in_bad;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [5:0]  wsum_y;
  logic [5:0]  wsum_m;
  logic [3:0]  m_units;
  logic [1:0]  leap_code;
  logic [51:0] image;

  always_comb begin
    in_bad = (date_word == 16'd0) || (date_word > DAY_LAST)
          || (hour_bcd[3:0] > 4'd9) || (hour_bcd[7:4] > 4'd2)
          || ((hour_bcd[7:4] == 4'd2) && (hour_bcd[3:0] > 4'd3))
          || (minute_bcd[3:0] > 4'd9) || (minute_bcd[7:4] > 4'd5)
          || (second_bcd[3:0] > 4'd9) || (second_bcd[7:4] > 4'd5);
    leap   = (ymod4 == 2'd0);
    ylen   = leap ? LEAP_LEN : YEAR_LEN;
    mlen   = month_len(month, leap);
    wsum_y = wacc + (leap ? 6'd2 : 6'd1);
    wsum_m = wacc + {1'b0, mlen - 5'd28};
    st.bad        = bad;
    st.year_fits  = (n <= {7'd0, ylen});
    st.month_fits = (n <= {11'd0, mlen}) || (month >= MONTH_LAST);
    st.fix_done   = (n < 16'd10) && (wacc < 6'd7);
    m_units   = (month >= 4'd10) ? (month - 4'd10) : month;
    leap_code = 2'(~ymod4 + 2'd1);
    image = {yy_tens, yy_units,
             {3'd0, (month >= 4'd10)}, m_units,
             {leap_code, dtens}, n[3:0],
             {1'b0, wacc[2:0]},
             (MODE_24H | hr[7:4]), hr[3:0],
             mi[7:4], mi[3:0],
             se[7:4], se[3:0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n        <= date_word;
      hr       <= hour_bcd;
      mi       <= minute_bcd;
      se       <= second_bcd;
      bad      <= in_bad;
      ymod4    <= YMOD4_0;
      yy_units <= YY_UNITS_0;
      yy_tens  <= YY_TENS_0;
      month    <= 4'd1;
      wacc     <= 6'd0;
      dtens    <= 2'd0;
    end
    if (cmd.year_step) begin
      n     <= n - {7'd0, ylen};
      ymod4 <= ymod4 + 2'd1;
      if (yy_units == 4'd9) begin
        yy_units <= 4'd0;
        yy_tens  <= (yy_tens == 4'd9) ? 4'd0 : yy_tens + 4'd1;
      end else begin
        yy_units <= yy_units + 4'd1;
      end
      wacc <= (wsum_y >= 6'd7) ? wsum_y - 6'd7 : wsum_y;
    end
    if (cmd.month_step) begin
      n     <= n - {11'd0, mlen};
      month <= month + 4'd1;
      wacc  <= (wsum_m >= 6'd7) ? wsum_m - 6'd7 : wsum_m;
    end
    if (cmd.add_day) begin
      wacc <= wacc + n[5:0] - 6'd1;
    end
    if (cmd.fix_step) begin
      if (n >= 16'd10) begin
        n     <= n - 16'd10;
        dtens <= dtens + 2'd1;
      end
      if (wacc >= 6'd7) begin
        wacc <= wacc - 6'd7;
      end
    end
    if (cmd.out_load) begin
      status         <= bad;
      register_image <= bad ? '0 : image;
    end
  end

endmodule
